/* design/arf_pkg.sv */
// Shared types and constants of the aging request FIFO.
`timescale 1ns / 1ps
package arf_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = 7;
  localparam int ID_W = 16;
  localparam int KIND_W = 2;
  localparam int PAY_W = 31;
  localparam int TIME_W = 32;
  localparam int TMO_W = 20;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_REGISTER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VIDEO = 2'd1;

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_VIDEO_TMO = 2'd1;
  localparam logic [1:0] REG_OTHER_TMO = 2'd2;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;
  localparam logic [TMO_W-1:0] TMO_RESET = 20'd1000;

  typedef struct packed {
    logic [CNT_W-1:0] capacity;
    logic [TMO_W-1:0] video_tmo;
    logic [TMO_W-1:0] other_tmo;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]   req_id;
    logic [KIND_W-1:0] kind;
    logic [PAY_W-1:0]  payload;
    logic [TIME_W-1:0] created_ms;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ins;   // insert transfer accepted this cycle
    logic take;  // take transfer accepted this cycle
    logic drop;  // discard expired head
    logic done;  // finish take: pop head if any, post result
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic head_expired;
  } stat_t;

endpackage

/* design/arf_regs.sv */
// APB-style configuration registers of the aging request FIFO.
`timescale 1ns / 1ps
module arf_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [arf_pkg::ADDR_W-1:0]  paddr,
  input  logic [arf_pkg::DATA_W-1:0]  pwdata,
  output logic [arf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output arf_pkg::cfg_t               cfg
);
  import arf_pkg::*;

  cfg_t cfg_r;
  logic wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign idx = paddr[3:2];
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.capacity <= CAP_RESET;
      cfg_r.video_tmo <= TMO_RESET;
      cfg_r.other_tmo <= TMO_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_CAPACITY:  cfg_r.capacity <= pwdata[CNT_W-1:0];
        REG_VIDEO_TMO: cfg_r.video_tmo <= pwdata[TMO_W-1:0];
        REG_OTHER_TMO: cfg_r.other_tmo <= pwdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CAPACITY:  prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_r.capacity};
      REG_VIDEO_TMO: prdata = {{(DATA_W-TMO_W){1'b0}}, cfg_r.video_tmo};
      REG_OTHER_TMO: prdata = {{(DATA_W-TMO_W){1'b0}}, cfg_r.other_tmo};
      default:       prdata = '0;
    endcase
  end

endmodule

/* design/arf_ctrl.sv */
// Controller state machine: sequences inserts, head expiry walk and takes.
`timescale 1ns / 1ps
module arf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_op,
  input  arf_pkg::stat_t stat,
  output logic           busy,
  output arf_pkg::cmd_t  cmd
);
  import arf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic accept;

  assign busy = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_TAKE) begin
            cmd.take = 1'b1;
            state_nxt = S_CHECK;
          end else begin
            cmd.ins = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (!stat.empty && stat.head_expired) begin
          cmd.drop = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          cmd.done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      // head moved: read data of the new head lands at the end of this cycle
      S_WAIT: state_nxt = S_CHECK;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/arf_datapath.sv */
// Datapath: entry memory, pointers, fill count, expiry check, result registers.
`timescale 1ns / 1ps
module arf_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  arf_pkg::cfg_t               cfg,
  input  arf_pkg::cmd_t               cmd,
  output arf_pkg::stat_t              stat,
  input  logic [arf_pkg::TIME_W-1:0]  in_now_ms,
  input  logic [arf_pkg::ID_W-1:0]    in_req_id,
  input  logic [arf_pkg::KIND_W-1:0]  in_kind,
  input  logic [arf_pkg::PAY_W-1:0]   in_payload,
  input  logic [arf_pkg::TIME_W-1:0]  in_created_ms,
  output logic                        out_valid,
  output logic                        out_accepted,
  output logic                        out_item_valid,
  output logic [arf_pkg::ID_W-1:0]    out_req_id,
  output logic [arf_pkg::KIND_W-1:0]  out_kind,
  output logic [arf_pkg::PAY_W-1:0]   out_payload,
  output logic [arf_pkg::TIME_W-1:0]  out_created_ms,
  output logic [arf_pkg::CNT_W-1:0]   out_discarded,
  output logic [arf_pkg::CNT_W-1:0]   out_fill_count,
  output logic                        out_at_most_half,
  output logic                        out_full_flag,
  output logic                        out_empty_flag
);
  import arf_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_r;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] dropped_r;
  logic [TIME_W-1:0] now_r;

  logic out_valid_r;
  logic acc_r;
  logic item_valid_r;
  entry_t item_r;
  logic is_take_r;

  logic [CNT_W-1:0] eff_cap;
  logic [CNT_W-1:0] half_cap;
  logic ins_ok;
  logic pop;
  logic [TIME_W-1:0] age;
  logic [TIME_W-1:0] tmo;
  entry_t wr_entry;
  logic [CNT_W-1:0] disc_hold;

  // capacity above the storage depth saturates
  assign eff_cap = (cfg.capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cfg.capacity;
  assign half_cap = CNT_W'(({1'b0, eff_cap} + 8'd1) >> 1);

  assign ins_ok = cmd.ins && (count_r < eff_cap);
  assign pop = cmd.drop || (cmd.done && !stat.empty);

  assign age = now_r - rd_r.created_ms;
  assign tmo = (rd_r.kind == KIND_VIDEO) ? {{(TIME_W-TMO_W){1'b0}}, cfg.video_tmo}
                                         : {{(TIME_W-TMO_W){1'b0}}, cfg.other_tmo};
  assign stat.empty = (count_r == '0);
  assign stat.head_expired = (rd_r.kind != KIND_REGISTER) && (age >= tmo);

  assign wr_entry.req_id = in_req_id;
  assign wr_entry.kind = in_kind;
  assign wr_entry.payload = in_payload;
  assign wr_entry.created_ms = in_created_ms;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    count_nxt = count_r;
    if (ins_ok) begin
      tail_nxt = tail_r + PTR_W'(1);
      count_nxt = count_r + CNT_W'(1);
    end else if (pop) begin
      head_nxt = head_r + PTR_W'(1);
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ins_ok) begin
      mem[tail_r] <= wr_entry;
    end
    rd_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      count_r <= '0;
      dropped_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      count_r <= count_nxt;
      out_valid_r <= cmd.ins || cmd.done;
      if (cmd.take) begin
        dropped_r <= '0;
      end else if (cmd.drop) begin
        dropped_r <= dropped_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      now_r <= in_now_ms;
    end
    if (cmd.ins) begin
      acc_r <= ins_ok;
      item_valid_r <= 1'b0;
      item_r <= '0;
    end else if (cmd.done) begin
      acc_r <= 1'b0;
      item_valid_r <= !stat.empty;
      item_r <= stat.empty ? '0 : rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      is_take_r <= 1'b0;
    end else if (cmd.done) begin
      is_take_r <= 1'b1;
    end
  end

  // discarded reads zero for insert results
  assign disc_hold = is_take_r ? dropped_r : '0;

  assign out_valid = out_valid_r;
  assign out_accepted = acc_r;
  assign out_item_valid = item_valid_r;
  assign out_req_id = item_r.req_id;
  assign out_kind = item_r.kind;
  assign out_payload = item_r.payload;
  assign out_created_ms = item_r.created_ms;
  assign out_discarded = disc_hold;

  // status follows the count, which holds during the result cycle
  assign out_fill_count = count_r;
  assign out_at_most_half = (count_r <= half_cap);
  assign out_full_flag = (count_r == eff_cap);
  assign out_empty_flag = stat.empty;

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    tail_r == PTR_W'(head_r + count_r[PTR_W-1:0]))
    else $error("pointers disagree with fill count");
  assert property (@(posedge clk) disable iff (!rst_n) cmd.drop |-> !stat.empty)
    else $error("discard from empty fifo");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drop |=> !cmd.done && !cmd.drop)
    else $error("expiry check on stale read data");

endmodule

/* design/aging_request_fifo.sv */
// Aging request FIFO: insert, and take with discard of expired head entries.
// Insert: result strobed the cycle after the start transfer; busy stays low.
// Take: busy while the head is checked and expired heads are discarded, result strobed
//   in the cycle after; each discard costs a head pop plus a memory read (S_WAIT).
// A new item may start in the cycle its predecessor's result is strobed.
// Synchronous active-low reset empties the fifo and loads register defaults.
`timescale 1ns / 1ps
module aging_request_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [arf_pkg::ADDR_W-1:0]  paddr,
  input  logic [arf_pkg::DATA_W-1:0]  pwdata,
  output logic [arf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_op,
  input  logic [arf_pkg::TIME_W-1:0]  in_now_ms,
  input  logic [arf_pkg::ID_W-1:0]    in_req_id,
  input  logic [arf_pkg::KIND_W-1:0]  in_kind,
  input  logic [arf_pkg::PAY_W-1:0]   in_payload,
  input  logic [arf_pkg::TIME_W-1:0]  in_created_ms,
  output logic                        out_valid,
  output logic                        out_accepted,
  output logic                        out_item_valid,
  output logic [arf_pkg::ID_W-1:0]    out_req_id,
  output logic [arf_pkg::KIND_W-1:0]  out_kind,
  output logic [arf_pkg::PAY_W-1:0]   out_payload,
  output logic [arf_pkg::TIME_W-1:0]  out_created_ms,
  output logic [arf_pkg::CNT_W-1:0]   out_discarded,
  output logic [arf_pkg::CNT_W-1:0]   out_fill_count,
  output logic                        out_at_most_half,
  output logic                        out_full_flag,
  output logic                        out_empty_flag
);
  import arf_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  stat_t stat;

  arf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  arf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  arf_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .stat             (stat),
    .in_now_ms        (in_now_ms),
    .in_req_id        (in_req_id),
    .in_kind          (in_kind),
    .in_payload       (in_payload),
    .in_created_ms    (in_created_ms),
    .out_valid        (out_valid),
    .out_accepted     (out_accepted),
    .out_item_valid   (out_item_valid),
    .out_req_id       (out_req_id),
    .out_kind         (out_kind),
    .out_payload      (out_payload),
    .out_created_ms   (out_created_ms),
    .out_discarded    (out_discarded),
    .out_fill_count   (out_fill_count),
    .out_at_most_half (out_at_most_half),
    .out_full_flag    (out_full_flag),
    .out_empty_flag   (out_empty_flag)
  );

endmodule
